### src/cfe_pkg.sv
// Shared types and constants for the command frame encoder.
package cfe_pkg;

  typedef enum logic [3:0] {
    CMD_PING     = 4'd0,
    CMD_RESET    = 4'd1,
    CMD_POWEROFF = 4'd2,
    CMD_START    = 4'd3,
    CMD_START_WD = 4'd4,
    CMD_RELOAD   = 4'd5,
    CMD_BATTERY  = 4'd6,
    CMD_STATE    = 4'd7,
    CMD_FWD      = 4'd8,
    CMD_BACK     = 4'd9,
    CMD_LEFT     = 4'd10,
    CMD_RIGHT    = 4'd11,
    CMD_STOP     = 4'd12,
    CMD_MOVE     = 4'd13,
    CMD_TURN     = 4'd14,
    CMD_INVALID  = 4'd15
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_LABEL,
    ST_SEP,
    ST_SIGN,
    ST_DIGIT,
    ST_SUM,
    ST_END,
    ST_BAD
  } state_t;

  localparam int          CMD_W       = 4;
  localparam logic [19:0] FIXED_SPEED = 20'd500000;
  localparam logic [7:0]  SEP_CHAR    = 8'h3D;
  localparam logic [7:0]  MINUS_CHAR  = 8'h2D;
  localparam logic [7:0]  END_CHAR    = 8'h0D;
  localparam logic [7:0]  DIGIT_BASE  = 8'h30;

  // Label letter that opens the frame of each valid command.
  function automatic logic [7:0] label_of(input cmd_t cmd);
    logic [7:0] lbl;
    case (cmd)
      CMD_PING:     lbl = 8'h70;  // p
      CMD_RESET:    lbl = 8'h72;  // r
      CMD_POWEROFF: lbl = 8'h7A;  // z
      CMD_START:    lbl = 8'h75;  // u
      CMD_START_WD: lbl = 8'h57;  // W
      CMD_RELOAD:   lbl = 8'h77;  // w
      CMD_BATTERY:  lbl = 8'h76;  // v
      CMD_STATE:    lbl = 8'h62;  // b
      CMD_FWD, CMD_BACK, CMD_STOP, CMD_MOVE: lbl = 8'h4D;  // M
      CMD_LEFT, CMD_RIGHT, CMD_TURN:         lbl = 8'h54;  // T
      default:      lbl = 8'h00;
    endcase
    return lbl;
  endfunction

endpackage

### src/command_frame_encoder_top.sv
// Command frame encoder: turns one command word into its serial ASCII frame.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  in_      | slave     | tdata: command[3:0], argument[ARG_WIDTH+3:4], zero pad
//  out_     | master    | tdata: frame_byte[7:0]; tlast: last_byte; tuser: bad_command
//
// Sequence per word: a plain command is taken, then sends its label, checksum and end byte.
// A motion command first runs one shift-and-add-3 step of the binary to decimal converter
// per bit of MAG_W (the larger of ARG_WIDTH and 20, 32 by default) and puts the separator,
// a sign if negative and NUM_DIG digits (10 by default, leading zeros hidden) after the label.
// Each output byte waits while out_tready is low, and no new input word is taken until
// the closing word has gone. Reset only returns the sequencer to idle.
module command_frame_encoder_top #(
  parameter int ARG_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0 up: command (4 bits), argument (ARG_WIDTH bits), zero pad.
  input  logic [((cfe_pkg::CMD_W+ARG_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Fields from bit 0 up: frame_byte (8 bits).
  output logic [7:0]                            out_tdata,
  output logic                                  out_tlast,
  // Fields from bit 0 up: bad_command (1 bit).
  output logic                                  out_tuser
);

  // The magnitude register must also hold the fixed speed of 500000.
  localparam int MAG_W   = (ARG_WIDTH > 20) ? ARG_WIDTH : 20;
  // Decimal digits needed for MAG_W bits: floor(MAG_W * log10(2)) + 1.
  localparam int NUM_DIG = (MAG_W * 30103) / 100000 + 1;
  localparam int BCD_W   = NUM_DIG * 4;
  localparam int CNT_W   = $clog2(MAG_W);
  localparam int DIG_W   = $clog2(NUM_DIG);

  cfe_pkg::state_t      state_r, state_nxt;
  logic [7:0]           label_r;
  logic                 motion_r;
  logic                 neg_r;
  logic [MAG_W-1:0]     mag_r;
  logic [BCD_W-1:0]     bcd_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIG_W-1:0]     dig_r;
  logic                 started_r;
  logic [7:0]           sum_r;

  cfe_pkg::cmd_t        in_cmd;
  logic [ARG_WIDTH-1:0] in_arg;
  logic [ARG_WIDTH-1:0] arg_abs;
  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           cur_dig;
  logic                 dig_show;
  logic                 dig_last;
  logic                 in_fire;
  logic                 out_fire;
  logic                 conv_done;

  assign in_cmd    = cfe_pkg::cmd_t'(in_tdata[cfe_pkg::CMD_W-1:0]);
  assign in_arg    = in_tdata[cfe_pkg::CMD_W +: ARG_WIDTH];
  assign arg_abs   = in_arg[ARG_WIDTH-1] ? (~in_arg + 1'b1) : in_arg;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign conv_done = (cnt_r == CNT_W'(MAG_W - 1));

  // The most significant BCD digit always sits at the top; digits shift up.
  assign cur_dig  = bcd_r[BCD_W-1 -: 4];
  assign dig_last = (dig_r == DIG_W'(NUM_DIG - 1));
  assign dig_show = started_r || (cur_dig != 4'd0) || dig_last;

  // Shared converter step: add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int d = 0; d < NUM_DIG; d++) begin
      bcd_adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? (bcd_r[d*4 +: 4] + 4'd3)
                                                     : bcd_r[d*4 +: 4];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfe_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == cfe_pkg::CMD_INVALID) begin
            state_nxt = cfe_pkg::ST_BAD;
          end else if (in_cmd >= cfe_pkg::CMD_FWD) begin
            state_nxt = cfe_pkg::ST_CONV;
          end else begin
            state_nxt = cfe_pkg::ST_LABEL;
          end
        end
      end
      cfe_pkg::ST_CONV: begin
        if (conv_done) begin
          state_nxt = cfe_pkg::ST_LABEL;
        end
      end
      cfe_pkg::ST_LABEL: begin
        if (out_fire) begin
          state_nxt = motion_r ? cfe_pkg::ST_SEP : cfe_pkg::ST_SUM;
        end
      end
      cfe_pkg::ST_SEP: begin
        if (out_fire) begin
          state_nxt = neg_r ? cfe_pkg::ST_SIGN : cfe_pkg::ST_DIGIT;
        end
      end
      cfe_pkg::ST_SIGN: begin
        if (out_fire) begin
          state_nxt = cfe_pkg::ST_DIGIT;
        end
      end
      cfe_pkg::ST_DIGIT: begin
        if (dig_last && out_fire) begin
          state_nxt = cfe_pkg::ST_SUM;
        end
      end
      cfe_pkg::ST_SUM: begin
        if (out_fire) begin
          state_nxt = cfe_pkg::ST_END;
        end
      end
      cfe_pkg::ST_END, cfe_pkg::ST_BAD: begin
        if (out_fire) begin
          state_nxt = cfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfe_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    out_tdata  = 8'h00;
    out_tlast  = 1'b0;
    out_tuser  = 1'b0;
    case (state_r)
      cfe_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      cfe_pkg::ST_LABEL: begin
        out_tvalid = 1'b1;
        out_tdata  = label_r;
      end
      cfe_pkg::ST_SEP: begin
        out_tvalid = 1'b1;
        out_tdata  = cfe_pkg::SEP_CHAR;
      end
      cfe_pkg::ST_SIGN: begin
        out_tvalid = 1'b1;
        out_tdata  = cfe_pkg::MINUS_CHAR;
      end
      cfe_pkg::ST_DIGIT: begin
        out_tvalid = dig_show;
        out_tdata  = cfe_pkg::DIGIT_BASE | {4'h0, cur_dig};
      end
      cfe_pkg::ST_SUM: begin
        out_tvalid = 1'b1;
        out_tdata  = sum_r;
      end
      cfe_pkg::ST_END: begin
        out_tvalid = 1'b1;
        out_tdata  = cfe_pkg::END_CHAR;
        out_tlast  = 1'b1;
      end
      cfe_pkg::ST_BAD: begin
        out_tvalid = 1'b1;
        out_tlast  = 1'b1;
        out_tuser  = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      label_r   <= cfe_pkg::label_of(in_cmd);
      motion_r  <= (in_cmd >= cfe_pkg::CMD_FWD);
      bcd_r     <= '0;
      cnt_r     <= '0;
      dig_r     <= '0;
      started_r <= 1'b0;
      sum_r     <= 8'h00;
      case (in_cmd)
        cfe_pkg::CMD_FWD, cfe_pkg::CMD_RIGHT: begin
          neg_r <= 1'b0;
          mag_r <= MAG_W'(cfe_pkg::FIXED_SPEED);
        end
        cfe_pkg::CMD_BACK, cfe_pkg::CMD_LEFT: begin
          neg_r <= 1'b1;
          mag_r <= MAG_W'(cfe_pkg::FIXED_SPEED);
        end
        cfe_pkg::CMD_MOVE, cfe_pkg::CMD_TURN: begin
          neg_r <= in_arg[ARG_WIDTH-1];
          mag_r <= MAG_W'(arg_abs);
        end
        default: begin
          neg_r <= 1'b0;
          mag_r <= '0;
        end
      endcase
    end else begin
      case (state_r)
        cfe_pkg::ST_CONV: begin
          bcd_r <= {bcd_adj[BCD_W-2:0], mag_r[MAG_W-1]};
          mag_r <= {mag_r[MAG_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
        end
        cfe_pkg::ST_DIGIT: begin
          // A hidden leading zero advances at once; a shown digit waits.
          if (!dig_show || out_fire) begin
            bcd_r <= {bcd_r[BCD_W-5:0], 4'h0};
            dig_r <= dig_r + 1'b1;
          end
          if (out_fire) begin
            started_r <= 1'b1;
            sum_r     <= sum_r ^ out_tdata;
          end
        end
        cfe_pkg::ST_LABEL, cfe_pkg::ST_SEP, cfe_pkg::ST_SIGN: begin
          if (out_fire) begin
            sum_r <= sum_r ^ out_tdata;
          end
        end
        default: begin
          sum_r <= sum_r;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The block never offers a result while it is open for a new word.
  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is offered");

  // The error flag only rides on a closing word.
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tuser |-> out_tlast)
    else $error("bad_command without last_byte");

  // Once the closing word is taken, the block is free again.
  a_free_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not ready after the end of a frame");

  // Digit bytes are always ASCII '0' to '9'.
  a_digit_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cfe_pkg::ST_DIGIT && out_tvalid) |->
      (out_tdata[7:4] == 4'h3 && out_tdata[3:0] <= 4'd9))
    else $error("digit byte out of range");
`endif

endmodule

### tb/command_frame_encoder_top_tb.sv
// Self-checking testbench for the command frame encoder: directed and random command words.
`timescale 1ns / 1ps

module command_frame_encoder_top_tb;

  localparam int ARG_W      = 32;
  localparam int IN_W       = ((cfe_pkg::CMD_W + ARG_W + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 60;

  // One expected byte of an encoded frame, with its end and error flags.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } frame_byte_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  // Fields from bit 0 up: command (4 bits), argument (ARG_W bits), zero pad.
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  // Fields from bit 0 up: frame_byte (8 bits).
  logic [7:0]      out_tdata;
  logic            out_tlast;
  // Fields from bit 0 up: bad_command (1 bit).
  logic            out_tuser;

  frame_byte_t expected_bytes_q[$];

  int  error_count   = 0;
  int  words_sent    = 0;
  int  bytes_checked = 0;
  int  bad_words     = 0;
  int  idle_cycles   = 0;
  bit  gaps_on       = 1'b0;
  bit  stalls_on     = 1'b0;

  command_frame_encoder_top #(.ARG_WIDTH(ARG_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Builds the frame the block should emit for one command word and queues
  // every byte of it. The checksum is the XOR of all bytes before it.
  function automatic void encode_frame(input cfe_pkg::cmd_t cmd,
                                       input logic [ARG_W-1:0] arg);
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    logic [7:0]  label;
    logic [7:0]  sum;
    logic [63:0] mag;
    logic        neg;
    frame_byte_t fb;
    if (cmd == cfe_pkg::CMD_INVALID) begin
      fb.data = 8'h00;
      fb.last = 1'b1;
      fb.bad  = 1'b1;
      expected_bytes_q.push_back(fb);
      return;
    end
    case (cmd)
      cfe_pkg::CMD_PING:     label = "p";
      cfe_pkg::CMD_RESET:    label = "r";
      cfe_pkg::CMD_POWEROFF: label = "z";
      cfe_pkg::CMD_START:    label = "u";
      cfe_pkg::CMD_START_WD: label = "W";
      cfe_pkg::CMD_RELOAD:   label = "w";
      cfe_pkg::CMD_BATTERY:  label = "v";
      cfe_pkg::CMD_STATE:    label = "b";
      cfe_pkg::CMD_LEFT, cfe_pkg::CMD_RIGHT, cfe_pkg::CMD_TURN: label = "T";
      default:               label = "M";
    endcase
    text.push_back(label);
    if (cmd >= cfe_pkg::CMD_FWD) begin
      text.push_back("=");
      neg = 1'b0;
      mag = 64'd500000;
      case (cmd)
        cfe_pkg::CMD_BACK, cfe_pkg::CMD_LEFT: neg = 1'b1;
        cfe_pkg::CMD_STOP:                    mag = 64'd0;
        cfe_pkg::CMD_MOVE, cfe_pkg::CMD_TURN: begin
          // The most negative argument negates to itself, which is the
          // right magnitude once read as unsigned.
          neg = arg[ARG_W-1];
          mag = {{(64-ARG_W){1'b0}}, neg ? -arg : arg};
        end
        default: ;
      endcase
      if (neg) text.push_back("-");
      do begin
        digits.push_front(8'h30 + 8'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 64'd0);
      foreach (digits[i]) text.push_back(digits[i]);
    end
    sum = 8'h00;
    foreach (text[i]) sum ^= text[i];
    text.push_back(sum);
    text.push_back(8'h0D);
    foreach (text[i]) begin
      fb.data = text[i];
      fb.last = (i == text.size() - 1);
      fb.bad  = 1'b0;
      expected_bytes_q.push_back(fb);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Sender gaps: half of the words follow straight on, most of the rest
  // after a short pause, a few after a long one.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Presents one command word and returns at the edge where it is taken.
  // The expected frame is queued up front: the block cannot answer before
  // it has taken the word, and it takes no word while a frame is pending.
  task automatic send_command(input cfe_pkg::cmd_t cmd, input logic [ARG_W-1:0] arg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-cfe_pkg::CMD_W-ARG_W){1'b0}}, arg, cmd};
    encode_frame(cmd, arg);
    words_sent++;
    if (cmd == cfe_pkg::CMD_INVALID) bad_words++;
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the input off until every queued byte has been taken. It always
  // waits on the clock first, so the next word never reuses this time step.
  task automatic wait_frames_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bytes_q.size() != 0);
  endtask

  // Random argument: full-range for four draws in ten, otherwise around the interesting
  // boundaries where the digit count or the sign changes.
  function automatic logic [ARG_W-1:0] pick_argument();
    int r;
    logic [ARG_W-1:0] v;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: v = $urandom;
      4:          v = $urandom_range(0, 20);
      5:          v = -$urandom_range(0, 20);
      6:          v = {1'b1, {(ARG_W-1){1'b0}}} + $urandom_range(0, 3);
      7:          v = {1'b0, {(ARG_W-1){1'b1}}} - $urandom_range(0, 3);
      default: begin
        // A power of ten plus or minus one, either sign.
        v = 1;
        repeat ($urandom_range(1, 9)) v = v * 10;
        v = v + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // The status commands ignore the argument, so they get random ones.
  task automatic check_status_commands();
    for (int c = cfe_pkg::CMD_PING; c <= cfe_pkg::CMD_STATE; c++)
      send_command(cfe_pkg::cmd_t'(c), $urandom);
  endtask

  // Forward, backward, left and right carry a fixed speed; stop carries zero.
  task automatic check_fixed_motion();
    for (int c = cfe_pkg::CMD_FWD; c <= cfe_pkg::CMD_STOP; c++)
      send_command(cfe_pkg::cmd_t'(c), $urandom);
  endtask

  // Move and turn at the argument extremes: zero, one digit, carries into
  // a new digit, and both ends of the signed range.
  task automatic check_argument_extremes();
    send_command(cfe_pkg::CMD_MOVE, 32'sd0);
    send_command(cfe_pkg::CMD_MOVE, 32'sd1);
    send_command(cfe_pkg::CMD_MOVE, -32'sd1);
    send_command(cfe_pkg::CMD_MOVE, 32'sd9);
    send_command(cfe_pkg::CMD_MOVE, 32'sd10);
    send_command(cfe_pkg::CMD_MOVE, 32'h7FFF_FFFF);
    send_command(cfe_pkg::CMD_MOVE, 32'h8000_0000);
    send_command(cfe_pkg::CMD_TURN, 32'h8000_0000);
    send_command(cfe_pkg::CMD_TURN, 32'h7FFF_FFFF);
    send_command(cfe_pkg::CMD_TURN, -32'sd1000000000);
    send_command(cfe_pkg::CMD_TURN, 32'sd0);
  endtask

  // The one code with no frame must give a single error word.
  task automatic check_bad_code();
    send_command(cfe_pkg::CMD_INVALID, $urandom);
  endtask

  // Random traffic. Move and turn dominate because they exercise the
  // decimal conversion; every code still comes up. The first stretch runs
  // without gaps or stalls, and now and then the sender waits for the
  // block to empty completely before it goes on.
  task automatic check_random_traffic(input int count);
    int            r;
    cfe_pkg::cmd_t cmd;
    for (int n = 0; n < count; n++) begin
      if (n == count / 4) begin
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
      end
      if (n % 60 == 59) wait_frames_drained();
      r = $urandom_range(0, 9);
      if (r < 5)
        cmd = $urandom_range(0, 1) ? cfe_pkg::CMD_MOVE : cfe_pkg::CMD_TURN;
      else if (r < 9)
        cmd = cfe_pkg::cmd_t'($urandom_range(cfe_pkg::CMD_PING, cfe_pkg::CMD_TURN));
      else
        cmd = cfe_pkg::cmd_t'($urandom_range(cfe_pkg::CMD_PING, cfe_pkg::CMD_INVALID));
      send_command(cmd, pick_argument());
    end
  endtask

  // Receiver: short ready runs, short stalls, and a few long
  // ones. With stalls off the output is always ready.
  always @(posedge clk) begin : ready_gen
    int r;
    int left;
    if (!stalls_on) begin
      out_tready <= 1'b1;
      left = 0;
    end else if (left == 0) begin
      r = $urandom_range(0, 99);
      out_tready <= (r < 60);
      if (r < 60)      left = $urandom_range(1, 8);
      else if (r < 90) left = $urandom_range(1, 3);
      else             left = $urandom_range(15, 40);
    end else begin
      left = left - 1;
    end
  end

  // Every byte the block hands over is compared with the oldest expected one.
  always @(posedge clk) begin : frame_checker
    frame_byte_t fb;
    if (rst_n && out_tvalid && out_tready) begin
      bytes_checked++;
      if (expected_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_tdata));
      end else begin
        fb = expected_bytes_q.pop_front();
        if (out_tdata !== fb.data)
          report_mismatch($sformatf("frame byte %02h, wanted %02h", out_tdata, fb.data));
        if (out_tlast !== fb.last)
          report_mismatch($sformatf("last flag %b, wanted %b on byte %02h",
                                    out_tlast, fb.last, fb.data));
        if (out_tuser !== fb.bad)
          report_mismatch($sformatf("bad-command flag %b, wanted %b on byte %02h",
                                    out_tuser, fb.bad, fb.data));
      end
    end
  end

  // Watchdog: a stretch with no word moving on either side that runs past the limit is a hang.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no progress for %0d cycles, %0d bytes still expected",
               IDLE_LIMIT, expected_bytes_q.size());
      $display("[command_frame_encoder_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_status_commands();
    check_fixed_motion();
    check_argument_extremes();
    check_bad_code();
    check_random_traffic(400);

    // Let the last frame finish, then give the block time to show any
    // stray bytes it should not produce.
    wait_frames_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (expected_bytes_q.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes_q.size()));

    $display("Encoded %0d command words (%0d with the invalid code), checked %0d bytes.",
             words_sent, bad_words, bytes_checked);
    $display("Covered all codes, argument extremes, sender gaps and receiver stalls.");
    if (error_count == 0) begin
      $display("[command_frame_encoder_top] OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[command_frame_encoder_top] ERROR");
    end
    $finish;
  end

endmodule
